// ===== hw/rtl/rnra_pkg.sv =====
// Shared constants and types for the ring neighbour resource arbiter.
package rnra_pkg;

  // Field widths fixed by the item format.
  localparam int MEMBER_W = 5;
  localparam int RING_W   = 6;
  localparam int STATUS_W = 2;

  // Default ring capacity and the ring size after reset.
  localparam int MEMBERS_DEFAULT = 32;
  localparam logic [RING_W-1:0] RING_SIZE_RESET = 6'd5;

  // At most this many grants are issued for one release.
  localparam int GRANT_LIMIT = 16;
  localparam int CNT_W       = $clog2(GRANT_LIMIT + 1);

  // Item kinds.
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_BAD_STATE = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/rnra_mod.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
module rnra_mod #(
  parameter int NW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rnra_pkg::MEMBER_W-1:0] dividend_i,
  input  logic [NW-1:0]                divisor_i,
  output logic                         done_o,
  output logic [NW-1:0]                rem_o
);
  import rnra_pkg::*;

  localparam int BW = $clog2(MEMBER_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [BW-1:0]       bit_q, bit_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [MEMBER_W-1:0] dvd_q, dvd_d;
  logic [NW:0]         shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    bit_d   = bit_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    shifted = {rem_q, dvd_q[bit_q]};
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BW'(MEMBER_W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so one subtract suffices.
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = NW'(shifted - {1'b0, divisor_i});
      end else begin
        rem_d = NW'(shifted);
      end
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/rnra_queue.sv =====
// Waiting queue storage: one write port and one registered read port.
module rnra_queue #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [rnra_pkg::MEMBER_W-1:0] wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [rnra_pkg::MEMBER_W-1:0] rdata_o
);
  import rnra_pkg::*;

  logic [MEMBER_W-1:0] mem_q [DEPTH];
  logic [MEMBER_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ring_neighbor_resource_arbiter.sv =====
// Ring neighbour resource arbiter: sequencer, member state and result register.
//
//   Channel  Direction  Signals                                  Transfer
//   item     in         start, busy, kind_i, member_i            start high while busy is low
//   config   in         cfg_valid_i, cfg_ready_o, cfg_data_i     valid and ready high
//   result   out        out_valid_o, granted_o, granted_member_o, one-cycle pulse per result,
//                       status_o, last_o                          no back-pressure
//
// A request, and any item that is flagged as bad, keeps the block busy only in ST_DEC
// after acceptance; its single result shows in the cycle after that.
// A release walks the waiting queue one entry at a time through the queue memory's
// single read port: each entry is read in ST_QRD and judged in ST_EVAL; an entry whose
// member sits at or above the current ring size is instead reduced in the remainder unit
// (ST_MOD), unless the grant cap is reached. Set-up is in ST_DEC, close in ST_FIN.
// Reset clears all members to thinking and empties the queue at once; there is no
// clearing pass. Results cannot be stalled, so the block never waits on the receiver.
module ring_neighbor_resource_arbiter #(
  parameter int MEMBERS = rnra_pkg::MEMBERS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item channel.
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [rnra_pkg::MEMBER_W-1:0] member_i,
  // Configuration channel: the ring size register.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rnra_pkg::RING_W-1:0]   cfg_data_i,
  // Result channel.
  output logic                         out_valid_o,
  output logic                         granted_o,
  output logic [rnra_pkg::MEMBER_W-1:0] granted_member_o,
  output logic [rnra_pkg::STATUS_W-1:0] status_o,
  output logic                         last_o
);
  import rnra_pkg::*;

  // IW indexes a member, NW holds a count of members up to MEMBERS itself.
  localparam int IW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  localparam int NW = $clog2(MEMBERS + 1);
  localparam int CW = (NW > MEMBER_W) ? NW : MEMBER_W;
  localparam int KW = (NW > RING_W) ? NW : RING_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(GRANT_LIMIT);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DEC  = 6'b000010,
    ST_QRD  = 6'b000100,
    ST_EVAL = 6'b001000,
    ST_MOD  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  typedef struct packed {
    logic                granted;
    logic [MEMBER_W-1:0] member;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

  state_e              state_q, state_d;
  logic                kind_q, kind_d;
  logic [MEMBER_W-1:0] mem_q, mem_d;
  logic [MEMBER_W-1:0] p_q, p_d;
  logic [MEMBERS-1:0]  eat_q, eat_d;
  logic [MEMBERS-1:0]  hungry_q, hungry_d;
  logic [NW-1:0]       wc_q, wc_d;
  logic [NW-1:0]       j_q, j_d;
  logic [NW-1:0]       w_q, w_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_v_q, pend_v_d;
  logic [MEMBER_W-1:0] pend_m_q, pend_m_d;
  logic                out_v_q, out_v_d;
  res_t                out_q, out_d;
  logic [RING_W-1:0]   ring_q;

  logic [KW-1:0]       ring_ext;
  logic [NW-1:0]       n;
  logic [IW-1:0]       n_m1;
  logic [IW-1:0]       nb_pm;
  logic [IW-1:0]       nb_left;
  logic [IW-1:0]       nb_right;
  logic                nb_free;
  logic [IW-1:0]       mem_idx;
  logic                mem_in_ring;
  logic                p_in_ring;
  logic [MEMBER_W-1:0] cand_p;
  logic                decide;
  logic                keep;

  logic                q_we;
  logic [IW-1:0]       q_waddr;
  logic [MEMBER_W-1:0] q_wdata;
  logic [MEMBER_W-1:0] q_rdata;
  logic                mod_start;
  logic                mod_done;
  logic [NW-1:0]       mod_rem;

  // Effective ring size: the register clamped to the range 2 .. MEMBERS.
  always_comb begin
    ring_ext = KW'(ring_q);
    if (ring_ext < KW'(2)) begin
      n = NW'(2);
    end else if (ring_ext > KW'(MEMBERS)) begin
      n = NW'(MEMBERS);
    end else begin
      n = NW'(ring_ext);
    end
  end

  assign n_m1        = IW'(n - 1'b1);
  assign mem_idx     = IW'(mem_q);
  assign mem_in_ring = CW'(mem_q) < CW'(n);
  assign p_in_ring   = CW'(q_rdata) < CW'(n);

  // The member under test is the item's own member, a queue entry just read, or the
  // reduced position of an out-of-ring queue entry from the remainder unit.
  assign nb_pm  = (state_q == ST_DEC) ? mem_idx :
                  (state_q == ST_MOD) ? IW'(mod_rem) : IW'(q_rdata);
  assign cand_p = (state_q == ST_MOD) ? p_q : q_rdata;

  // Shared neighbour test: both ring neighbours must be off the resources.
  assign nb_left  = (nb_pm == '0) ? n_m1 : nb_pm - 1'b1;
  assign nb_right = (nb_pm == n_m1) ? '0 : nb_pm + 1'b1;
  assign nb_free  = !eat_q[nb_left] && !eat_q[nb_right];

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    mem_d     = mem_q;
    p_d       = p_q;
    eat_d     = eat_q;
    hungry_d  = hungry_q;
    wc_d      = wc_q;
    j_d       = j_q;
    w_d       = w_q;
    cnt_d     = cnt_q;
    pend_v_d  = pend_v_q;
    pend_m_d  = pend_m_q;
    out_v_d   = 1'b0;
    out_d     = out_q;
    q_we      = 1'b0;
    q_waddr   = w_q[IW-1:0];
    q_wdata   = cand_p;
    mod_start = 1'b0;
    decide    = 1'b0;
    keep      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d  = kind_i;
          mem_d   = member_i;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_IDLE;
        out_v_d = 1'b1;
        out_d   = '{1'b0, '0, STATUS_OK, 1'b1};
        if (!mem_in_ring) begin
          out_d.status = STATUS_BAD_INDEX;
        end else if (kind_q == KIND_REQUEST) begin
          if (eat_q[mem_idx] || hungry_q[mem_idx] || (wc_q >= NW'(MEMBERS))) begin
            out_d.status = STATUS_BAD_STATE;
          end else if (nb_free) begin
            eat_d[mem_idx] = 1'b1;
            out_d.granted  = 1'b1;
            out_d.member   = mem_q;
          end else begin
            hungry_d[mem_idx] = 1'b1;
            q_we    = 1'b1;
            q_waddr = wc_q[IW-1:0];
            q_wdata = mem_q;
            wc_d    = wc_q + 1'b1;
          end
        end else if (!eat_q[mem_idx]) begin
          out_d.status = STATUS_BAD_STATE;
        end else begin
          // Release: start a compacting walk over the waiting queue.
          eat_d[mem_idx] = 1'b0;
          out_v_d  = 1'b0;
          j_d      = '0;
          w_d      = '0;
          cnt_d    = '0;
          pend_v_d = 1'b0;
          state_d  = ST_QRD;
        end
      end
      ST_QRD: begin
        state_d = (j_q == wc_q) ? ST_FIN : ST_EVAL;
      end
      ST_EVAL: begin
        j_d     = j_q + 1'b1;
        state_d = ST_QRD;
        if (cnt_q == CNT_LIMIT) begin
          keep = 1'b1;
        end else if (p_in_ring) begin
          decide = 1'b1;
        end else begin
          mod_start = 1'b1;
          p_d       = q_rdata;
          j_d       = j_q;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          decide  = 1'b1;
          j_d     = j_q + 1'b1;
          state_d = ST_QRD;
        end
      end
      ST_FIN: begin
        wc_d     = w_q;
        out_v_d  = 1'b1;
        out_d    = pend_v_q ? '{1'b1, pend_m_q, STATUS_OK, 1'b1} :
                              '{1'b0, '0, STATUS_OK, 1'b1};
        pend_v_d = 1'b0;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (decide) begin
      if (nb_free) begin
        eat_d[IW'(cand_p)]    = 1'b1;
        hungry_d[IW'(cand_p)] = 1'b0;
        cnt_d = cnt_q + 1'b1;
        // A grant is held back one step so that the final one can carry last.
        if (pend_v_q) begin
          out_v_d = 1'b1;
          out_d   = '{1'b1, pend_m_q, STATUS_OK, 1'b0};
        end
        pend_v_d = 1'b1;
        pend_m_d = cand_p;
      end else begin
        keep = 1'b1;
      end
    end

    if (keep) begin
      q_we    = 1'b1;
      q_waddr = w_q[IW-1:0];
      q_wdata = cand_p;
      w_d     = w_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      eat_q    <= '0;
      hungry_q <= '0;
      wc_q     <= '0;
      j_q      <= '0;
      w_q      <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      ring_q   <= RING_SIZE_RESET;
    end else begin
      state_q  <= state_d;
      eat_q    <= eat_d;
      hungry_q <= hungry_d;
      wc_q     <= wc_d;
      j_q      <= j_d;
      w_q      <= w_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ring_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    mem_q    <= mem_d;
    p_q      <= p_d;
    pend_m_q <= pend_m_d;
    out_q    <= out_d;
  end

  rnra_queue #(
    .DEPTH(MEMBERS),
    .AW   (IW)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(j_q[IW-1:0]),
    .rdata_o(q_rdata)
  );

  // The remainder unit latches its dividend on start, straight from the queue read.
  rnra_mod #(
    .NW(NW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(q_rdata),
    .divisor_i (n),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign busy             = (state_q != ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_v_q;
  assign granted_o        = out_q.granted;
  assign granted_member_o = out_q.member;
  assign status_o         = out_q.status;
  assign last_o           = out_q.last;

endmodule

// ===== hw/rtl/rnra_checker.sv =====
// Port-level checks for the ring neighbour resource arbiter, bound to the top level.
module rnra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid_o,
  input logic                         granted_o,
  input logic [rnra_pkg::MEMBER_W-1:0] granted_member_o,
  input logic [rnra_pkg::STATUS_W-1:0] status_o,
  input logic                         last_o
);
  import rnra_pkg::*;

  // An accepted item always keeps the block busy for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but block not busy afterwards");

  // A flagged item gives a single result that grants nothing.
  a_flag_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> !granted_o && last_o)
    else $error("flagged result grants or is not last");

  // A result without a grant carries member zero.
  a_no_grant_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> granted_member_o == '0)
    else $error("result without grant names a member");

  // The final result of an item shows only once the block is free again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == !busy))
    else $error("last flag disagrees with busy");

endmodule

bind ring_neighbor_resource_arbiter rnra_checker u_rnra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .out_valid_o     (out_valid_o),
  .granted_o       (granted_o),
  .granted_member_o(granted_member_o),
  .status_o        (status_o),
  .last_o          (last_o)
);

// ===== bench/rnra_outcome_check.sv =====
// Result checker for the ring neighbour resource arbiter: predicts each result and compares.
`timescale 1ns / 1ps
module rnra_outcome_check #(
  parameter int MEMBERS = rnra_pkg::MEMBERS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          kind_i,
  input  logic [rnra_pkg::MEMBER_W-1:0] member_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [rnra_pkg::RING_W-1:0]   cfg_data_i,
  input  logic                          out_valid_o,
  input  logic                          granted_o,
  input  logic [rnra_pkg::MEMBER_W-1:0] granted_member_o,
  input  logic [rnra_pkg::STATUS_W-1:0] status_o,
  input  logic                          last_o,
  output int                            fault_count,
  output int                            outcomes_due
);
  import rnra_pkg::*;

  typedef enum logic [1:0] {
    THINKING = 2'd0,
    HUNGRY   = 2'd1,
    EATING   = 2'd2
  } seat_e;

  typedef struct packed {
    logic                granted;
    logic [MEMBER_W-1:0] member;
    status_e             status;
    logic                last;
  } outcome_t;

  seat_e               seat [MEMBERS];
  logic [MEMBER_W-1:0] waiters [MEMBERS];
  int                  waiting;
  logic [RING_W-1:0]   ring_size;
  outcome_t            due_outcomes [$];

  // Out-of-range ring sizes are clamped to the usable span.
  function automatic int ring_len();
    int n;
    n = ring_size;
    if (n < 2) n = 2;
    if (n > MEMBERS) n = MEMBERS;
    return n;
  endfunction

  function automatic logic sides_free(int p, int n);
    return seat[(p + n - 1) % n] != EATING && seat[(p + 1) % n] != EATING;
  endfunction

  function automatic outcome_t outcome(logic g, int m, status_e s);
    outcome_t o;
    o.granted = g;
    o.member  = m[MEMBER_W-1:0];
    o.status  = s;
    o.last    = 1'b0;
    return o;
  endfunction

  task automatic unqueue(int j);
    for (int k = j; k + 1 < waiting; k++) waiters[k] = waiters[k + 1];
    waiting--;
  endtask

  // Works out the results of one accepted item and files them in order.
  task automatic arbitrate(logic kind, int m);
    int       n;
    int       j;
    int       p;
    outcome_t batch [$];
    n = ring_len();
    if (m >= n) begin
      batch.push_back(outcome(1'b0, 0, STATUS_BAD_INDEX));
    end else if (kind == KIND_REQUEST) begin
      if (seat[m] != THINKING || waiting >= MEMBERS) begin
        batch.push_back(outcome(1'b0, 0, STATUS_BAD_STATE));
      end else if (sides_free(m, n)) begin
        seat[m] = EATING;
        batch.push_back(outcome(1'b1, m, STATUS_OK));
      end else begin
        seat[m] = HUNGRY;
        waiters[waiting] = m[MEMBER_W-1:0];
        waiting++;
        batch.push_back(outcome(1'b0, 0, STATUS_OK));
      end
    end else if (seat[m] != EATING) begin
      batch.push_back(outcome(1'b0, 0, STATUS_BAD_STATE));
    end else begin
      seat[m] = THINKING;
      j = 0;
      while (j < waiting && batch.size() < GRANT_LIMIT) begin
        p = waiters[j];
        if (seat[p] != EATING && sides_free(p, n)) begin
          seat[p] = EATING;
          batch.push_back(outcome(1'b1, p, STATUS_OK));
          unqueue(j);
        end else begin
          j++;
        end
      end
      // Neighbour test of the releasing member; a grant here also leaves the queue.
      for (int t = 0; t < 2; t++) begin
        p = (t == 0) ? (m + n - 1) % n : (m + 1) % n;
        if (batch.size() >= GRANT_LIMIT) break;
        if (seat[p] == HUNGRY && sides_free(p, n)) begin
          seat[p] = EATING;
          batch.push_back(outcome(1'b1, p, STATUS_OK));
          for (int k = 0; k < waiting; k++) begin
            if (waiters[k] == p) begin
              unqueue(k);
              break;
            end
          end
        end
      end
      if (batch.size() == 0) batch.push_back(outcome(1'b0, 0, STATUS_OK));
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) due_outcomes.push_back(batch[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int       errs;
    outcome_t want;
    if (!rst_ni) begin
      foreach (seat[i]) seat[i] = THINKING;
      waiting = 0;
      ring_size = RING_SIZE_RESET;
      due_outcomes.delete();
      fault_count <= 0;
      outcomes_due <= 0;
    end else begin
      errs = 0;
      // Results of earlier items are checked before this edge's item is predicted.
      if (out_valid_o) begin
        if (due_outcomes.size() == 0) begin
          $error("Result with nothing awaited: granted %0d, member %0d, status %0d",
                 granted_o, granted_member_o, status_o);
          errs++;
        end else begin
          want = due_outcomes.pop_front();
          if (granted_o !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, granted_o);
            errs++;
          end
          if (granted_member_o !== want.member) begin
            $error("granted_member: expected %0d, actual %0d", want.member,
                   granted_member_o);
            errs++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            errs++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            errs++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) ring_size = cfg_data_i;
      if (start && !busy) arbitrate(kind_i, int'(member_i));
      fault_count <= fault_count + errs;
      outcomes_due <= due_outcomes.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the ring neighbour resource arbiter: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import rnra_pkg::*;

  // Longest stretch without any handshake before the run is declared hung. A release over
  // a full queue is slowest when most entries lie beyond a shrunk ring and pass through the
  // remainder unit, so this leaves a wide margin even with sender gaps.
  localparam int QUIET_LIMIT = 4000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                kind_i      = KIND_REQUEST;
  logic [MEMBER_W-1:0] member_i    = '0;
  logic                cfg_valid_i = 1'b0;
  logic [RING_W-1:0]   cfg_data_i  = '0;
  logic                busy;
  logic                cfg_ready_o;
  logic                out_valid_o;
  logic                granted_o;
  logic [MEMBER_W-1:0] granted_member_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  int fault_count;
  int outcomes_due;
  int idle_pct;
  int ring_eff;
  int items_sent  = 0;
  int ring_writes = 0;
  int quiet       = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  ring_neighbor_resource_arbiter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .member_i         (member_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .granted_o        (granted_o),
    .granted_member_o (granted_member_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  // The checker sits beside the block, watches every channel and counts failures.
  rnra_outcome_check outcome_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .member_i         (member_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .granted_o        (granted_o),
    .granted_member_o (granted_member_o),
    .status_o         (status_o),
    .last_o           (last_o),
    .fault_count      (fault_count),
    .outcomes_due     (outcomes_due)
  );

  // Watchdog: any accepted item, register write or result counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || out_valid_o) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAIL ring_neighbor_resource_arbiter");
      $finish;
    end
  end

  // Offers one item, idling at random first, and returns at the edge that accepts it.
  // Start is left high on return so that items can follow back to back; every
  // caller either drives the next item or lowers start in that same time step.
  task automatic send_item(logic kind, int mbr);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= kind;
    member_i <= mbr[MEMBER_W-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering items and waits until every awaited result has been seen. The
  // checker's count is registered, so it can be trusted only after the next edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outcomes_due != 0) @(posedge clk_i);
  endtask

  // Writes the ring size once the block has gone idle. The effective length is kept
  // here only to aim member indexes inside or outside the ring.
  task automatic set_ring(logic [RING_W-1:0] size);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ring_eff = (size < 2) ? 2 : (size > MEMBERS_DEFAULT) ? MEMBERS_DEFAULT : int'(size);
    ring_writes++;
  endtask

  // Random items, mostly on members inside the ring; the request share sets how long
  // the waiting queue tends to grow before releases drain it.
  task automatic random_burst(int count, int req_pct);
    logic kind;
    int   mbr;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(99, 0) < req_pct) ? KIND_REQUEST : KIND_RELEASE;
      if (ring_eff < MEMBERS_DEFAULT && $urandom_range(99, 0) < 12) begin
        mbr = $urandom_range(MEMBERS_DEFAULT - 1, ring_eff);
      end else begin
        mbr = $urandom_range(ring_eff - 1, 0);
      end
      send_item(kind, mbr);
    end
  endtask

  initial begin
    int hungry [$];
    int pick;
    int tmp;
    idle_pct = 10;
    ring_eff = RING_SIZE_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset ring of five. Member 0 eats, 1 and 4 queue behind it,
    // 2 eats and 3 queues behind 2.
    send_item(KIND_REQUEST, 0);
    send_item(KIND_REQUEST, 1);
    send_item(KIND_REQUEST, 4);
    send_item(KIND_REQUEST, 2);
    send_item(KIND_REQUEST, 3);
    // Wrong state: a second request by an eater, a release by a waiter.
    send_item(KIND_REQUEST, 0);
    send_item(KIND_RELEASE, 1);
    // Bad index: just past the ring, and the all-ones index.
    send_item(KIND_REQUEST, 5);
    send_item(KIND_RELEASE, 31);
    // Releases work through the queue in order; 1 stays blocked while 2 eats.
    send_item(KIND_RELEASE, 0);
    send_item(KIND_RELEASE, 2);
    send_item(KIND_RELEASE, 4);
    // Releases that free nobody give a single empty result.
    send_item(KIND_RELEASE, 1);
    send_item(KIND_RELEASE, 3);
    // One release granting two waiters at once.
    send_item(KIND_REQUEST, 1);
    send_item(KIND_REQUEST, 0);
    send_item(KIND_REQUEST, 2);
    send_item(KIND_RELEASE, 1);
    send_item(KIND_RELEASE, 0);
    send_item(KIND_RELEASE, 2);

    // Grant cap. On the full ring every third member eats and twenty others queue in
    // random order behind them. Shrinking the ring to two then makes every waiter a
    // neighbour of members 0 and 1 only, so releasing 1 frees them all at once and the
    // cap of sixteen grants leaves the rest queued beyond the shrunk ring.
    set_ring(6'd32);
    for (int k = 1; k < MEMBERS_DEFAULT; k += 3) send_item(KIND_REQUEST, k);
    for (int k = 2; k < MEMBERS_DEFAULT; k++) begin
      if (k % 3 != 1) hungry.push_back(k);
    end
    for (int k = hungry.size() - 1; k > 0; k--) begin
      pick = $urandom_range(k, 0);
      tmp = hungry[k];
      hungry[k] = hungry[pick];
      hungry[pick] = tmp;
    end
    for (int k = 0; k < hungry.size(); k++) send_item(KIND_REQUEST, hungry[k]);
    set_ring(6'd2);
    send_item(KIND_RELEASE, 1);

    // Random phases. Sizes below two and above the ring capacity are written as well,
    // and growing or shrinking the ring leaves members stranded outside it.
    set_ring(6'd1);
    random_burst(20, 50);
    set_ring(RING_W'($urandom_range(31, 3)));
    random_burst(35, 65);
    idle_pct = 48;
    set_ring(6'd63);
    random_burst(35, 70);
    set_ring(6'd0);
    random_burst(16, 50);
    idle_pct = 0;
    set_ring(RING_W'($urandom_range(62, 33)));
    random_burst(25, 60);
    set_ring(RING_W'($urandom_range(32, 2)));
    random_burst(25, 55);

    // Let the last results arrive, then leave room for any stray result to show up.
    drain();
    repeat (80) @(posedge clk_i);

    $display("Covered %0d items over %0d ring-size writes, from clamped tiny rings to the full",
             items_sent, ring_writes);
    $display("ring, with bad indexes, wrong-state items and a release held to the grant cap.");
    if (fault_count == 0) begin
      $display("PASS ring_neighbor_resource_arbiter");
    end else begin
      $display("FAIL ring_neighbor_resource_arbiter");
    end
    $finish;
  end

endmodule

// ===== ring_neighbor_resource_arbiter.f =====
hw/rtl/rnra_pkg.sv
hw/rtl/rnra_mod.sv
hw/rtl/rnra_queue.sv
hw/rtl/ring_neighbor_resource_arbiter.sv
hw/rtl/rnra_checker.sv
bench/rnra_outcome_check.sv
bench/tb.sv
